// File: rtl/core/rsp_pkg.sv
// rsp_pkg: shared types and constants of the reference star picker
// holds the register index codes, register reset values and the result struct
// no dependencies
package rsp_pkg;

  // configuration port geometry
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 9;

  // register field widths
  localparam int STAR_COUNT_W = 5;
  localparam int RADIUS_W     = 6;
  localparam int DIM_W        = 9;

  // result field widths
  localparam int OUT_IDX_W   = 4;
  localparam int OUT_COORD_W = 8;
  localparam int TOTAL_W     = 5;

  // register reset values
  localparam logic [STAR_COUNT_W-1:0] STAR_COUNT_RST = STAR_COUNT_W'(4);
  localparam logic [RADIUS_W-1:0]     RADIUS_RST     = RADIUS_W'(8);
  localparam logic [DIM_W-1:0]        ROWS_RST       = DIM_W'(256);
  localparam logic [DIM_W-1:0]        COLS_RST       = DIM_W'(256);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STAR_COUNT = 4'd0,
    REG_RADIUS     = 4'd1,
    REG_ROWS       = 4'd2,
    REG_COLS       = 4'd3
  } cfg_reg_t;

  // one pass result
  typedef struct packed {
    logic [OUT_IDX_W-1:0]   star_index;
    logic [OUT_COORD_W-1:0] star_col;
    logic [OUT_COORD_W-1:0] star_row;
    logic                   star_valid;
    logic [TOTAL_W-1:0]     stars_total;
    logic                   all_found;
    logic                   last_star;
  } star_res_t;

endpackage

// File: rtl/core/rsp_ifs.sv
// rsp_ifs: valid/ready channel interfaces of the reference star picker
// pixel input channel and star result channel; depends on nothing
interface rsp_pixel_if #(
  parameter int PIXEL_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_value;
  logic                  frame_end;

  modport source (output valid, output pixel_value, output frame_end, input ready);
  modport sink   (input valid, input pixel_value, input frame_end, output ready);
endinterface

interface rsp_star_if;
  logic       valid;
  logic       ready;
  logic [3:0] star_index;
  logic [7:0] star_col;
  logic [7:0] star_row;
  logic       star_valid;
  logic [4:0] stars_total;
  logic       all_found;
  logic       last_star;

  modport source (output valid, output star_index, output star_col, output star_row,
                  output star_valid, output stars_total, output all_found,
                  output last_star, input ready);
  modport sink   (input valid, input star_index, input star_col, input star_row,
                  input star_valid, input stars_total, input all_found,
                  input last_star, output ready);
endinterface

// File: rtl/core/rsp_frame_mem.sv
// rsp_frame_mem: frame store, one write port and one registered read port
// generic synchronous memory; no dependencies
module rsp_frame_mem #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered output
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/rsp_loader.sv
// rsp_loader: frame load position and image size clamping
// raster-order write address for the frame store; uses rsp_pkg
module rsp_loader #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256,
  localparam int RB = $clog2(MAX_ROWS),
  localparam int CB = $clog2(MAX_COLS),
  localparam int RW = $clog2(MAX_ROWS + 1),
  localparam int CW = $clog2(MAX_COLS + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [rsp_pkg::DIM_W-1:0] image_rows,
  input  logic [rsp_pkg::DIM_W-1:0] image_cols,
  input  logic                      accept,
  input  logic                      frame_end,
  output logic                      wr_en,
  output logic [RB+CB-1:0]          wr_addr,
  output logic                      start,
  output logic [RW-1:0]             rows_eff,
  output logic [CW-1:0]             cols_eff
);

  logic [RB-1:0] load_row, load_row_next;
  logic [CB-1:0] load_col, load_col_next;
  logic [RB-1:0] cur_row;
  logic [CB-1:0] cur_col;
  logic [RB:0]   row_inc;
  logic [CB:0]   col_inc;

  // zero reads as one, oversize saturates
  always_comb begin
    if (image_rows == '0) begin
      rows_eff = RW'(1);
    end else if (32'(image_rows) > MAX_ROWS) begin
      rows_eff = RW'(MAX_ROWS);
    end else begin
      rows_eff = RW'(image_rows);
    end
    if (image_cols == '0) begin
      cols_eff = CW'(1);
    end else if (32'(image_cols) > MAX_COLS) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = CW'(image_cols);
    end
  end

  // position of this pixel and of the next one
  always_comb begin
    cur_row = (RW'(load_row) >= rows_eff) ? '0 : load_row;
    cur_col = (CW'(load_col) >= cols_eff) ? '0 : load_col;
    row_inc = {1'b0, cur_row} + (RB+1)'(1);
    col_inc = {1'b0, cur_col} + (CB+1)'(1);
    if (frame_end) begin
      load_row_next = '0;
      load_col_next = '0;
    end else if (CW'(col_inc) >= cols_eff) begin
      load_col_next = '0;
      load_row_next = (RW'(row_inc) >= rows_eff) ? '0 : RB'(row_inc);
    end else begin
      load_col_next = CB'(col_inc);
      load_row_next = cur_row;
    end
  end

  assign wr_en   = accept;
  assign wr_addr = {cur_row, cur_col};
  assign start   = accept && frame_end;

  // load position
  always_ff @(posedge clk) begin
    if (rst) begin
      load_row <= '0;
      load_col <= '0;
    end else if (accept) begin
      load_row <= load_row_next;
      load_col <= load_col_next;
    end
  end

endmodule

// File: rtl/core/rsp_scan.sv
// rsp_scan: selection passes over the frame store
// one read per cycle, compare against the best so far, band exclusion
// against earlier picks; uses rsp_pkg
module rsp_scan #(
  parameter int MAX_ROWS   = 256,
  parameter int MAX_COLS   = 256,
  parameter int MAX_STARS  = 16,
  parameter int PIXEL_BITS = 16,
  localparam int RB = $clog2(MAX_ROWS),
  localparam int CB = $clog2(MAX_COLS),
  localparam int RW = $clog2(MAX_ROWS + 1),
  localparam int CW = $clog2(MAX_COLS + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [RW-1:0]                    rows_eff,
  input  logic [CW-1:0]                    cols_eff,
  input  logic [rsp_pkg::STAR_COUNT_W-1:0] star_count,
  input  logic [rsp_pkg::RADIUS_W-1:0]     radius,
  output logic                             idle,
  output logic                             rd_en,
  output logic [RB+CB-1:0]                 rd_addr,
  input  logic [PIXEL_BITS-1:0]            rd_data,
  output logic                             res_valid,
  input  logic                             res_ready,
  output rsp_pkg::star_res_t               res
);

  localparam int CNT_W  = $clog2(MAX_STARS + 1);
  localparam int SIDX_W = (MAX_STARS > 1) ? $clog2(MAX_STARS) : 1;
  localparam int BW     = ((RW > CW) ? ((RW > 8) ? RW : 8) : ((CW > 8) ? CW : 8)) + 1;
  localparam int CSW    = ((CB > rsp_pkg::RADIUS_W) ? CB : rsp_pkg::RADIUS_W) + 1;
  localparam int RSW    = ((RB > rsp_pkg::RADIUS_W) ? RB : rsp_pkg::RADIUS_W) + 1;

  typedef enum logic [2:0] {S_IDLE, S_INIT, S_SCAN, S_DRAIN, S_EMIT} state_t;

  state_t state;

  // control
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] tally;
  logic [CNT_W-1:0] tally_next;
  logic             found;
  logic             s_vld;
  logic             last_pass;

  // frame geometry latched at start
  logic [rsp_pkg::RADIUS_W-1:0] rad_q;
  logic [RB-1:0]                row_lo_q, row_hi_q;
  logic [CB-1:0]                col_lo_q, col_hi_q;
  logic                         empty_q;

  // scan position and read stage
  logic [RB-1:0]         r, s_r, best_r;
  logic [CB-1:0]         c, s_c, best_c;
  logic                  s_clear;
  logic [PIXEL_BITS-1:0] best;
  logic                  take;
  logic                  last_elem;

  // earlier picks
  logic [CB-1:0] pick_col [MAX_STARS];
  logic [RB-1:0] pick_row [MAX_STARS];

  // start-time geometry
  logic [rsp_pkg::RADIUS_W:0] border;
  logic [CNT_W-1:0]           count_eff;
  logic                       empty_now;

  // exclusion check
  logic [MAX_STARS-1:0] col_ok, row_ok, pick_ok;
  logic                 clear;

  assign border = {radius, 1'b0};

  // effective pass count and empty interior test
  always_comb begin
    if (star_count == '0) begin
      count_eff = CNT_W'(1);
    end else if (32'(star_count) > MAX_STARS) begin
      count_eff = CNT_W'(MAX_STARS);
    end else begin
      count_eff = CNT_W'(star_count);
    end
    empty_now = (BW'(rows_eff) <= BW'({border, 1'b0}))
             || (BW'(cols_eff) <= BW'({border, 1'b0}));
  end

  // band exclusion against picks of earlier passes
  always_comb begin
    for (int i = 0; i < MAX_STARS; i++) begin
      col_ok[i]  = (CSW'(c) > CSW'(pick_col[i]) + CSW'(rad_q))
                || (CSW'(c) + CSW'(rad_q) < CSW'(pick_col[i]));
      row_ok[i]  = (RSW'(r) > RSW'(pick_row[i]) + RSW'(rad_q))
                || (RSW'(r) + RSW'(rad_q) < RSW'(pick_row[i]));
      pick_ok[i] = (CNT_W'(i) >= k) || (col_ok[i] && row_ok[i]);
    end
    clear = &pick_ok;
  end

  // read issue and compare
  assign rd_en     = (state == S_SCAN);
  assign rd_addr   = {r, c};
  assign last_elem = (r == row_hi_q) && (c == col_hi_q);
  assign take      = s_vld && s_clear && (rd_data >= best);

  // pass result
  assign tally_next = tally + CNT_W'(found);
  assign last_pass  = ({1'b0, k} + (CNT_W+1)'(1)) == {1'b0, count_q};
  assign idle       = (state == S_IDLE);
  assign res_valid  = (state == S_EMIT);

  always_comb begin
    res.star_index  = rsp_pkg::OUT_IDX_W'(k);
    res.star_col    = rsp_pkg::OUT_COORD_W'(best_c);
    res.star_row    = rsp_pkg::OUT_COORD_W'(best_r);
    res.star_valid  = found;
    res.stars_total = last_pass ? rsp_pkg::TOTAL_W'(tally_next) : '0;
    res.all_found   = last_pass && (tally_next == count_q);
    res.last_star   = last_pass;
  end

  // pass sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      k       <= '0;
      count_q <= CNT_W'(1);
      tally   <= '0;
      found   <= 1'b0;
      s_vld   <= 1'b0;
    end else begin
      s_vld <= (state == S_SCAN);
      if (take) begin
        found <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            count_q <= count_eff;
            k       <= '0;
            tally   <= '0;
            state   <= S_INIT;
          end
        end
        S_INIT: begin
          found <= 1'b0;
          state <= empty_q ? S_EMIT : S_SCAN;
        end
        S_SCAN: begin
          if (last_elem) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (res_ready) begin
            tally <= tally_next;
            if (last_pass) begin
              state <= S_IDLE;
            end else begin
              k     <= k + CNT_W'(1);
              state <= S_INIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // geometry, scan position, best candidate and picks
  always_ff @(posedge clk) begin
    s_clear <= clear;
    s_r     <= r;
    s_c     <= c;
    if (take) begin
      best   <= rd_data;
      best_r <= s_r;
      best_c <= s_c;
    end
    if (state == S_IDLE && start) begin
      rad_q    <= radius;
      empty_q  <= empty_now;
      row_lo_q <= RB'(border);
      col_lo_q <= CB'(border);
      row_hi_q <= RB'(BW'(rows_eff) - BW'(border) - BW'(1));
      col_hi_q <= CB'(BW'(cols_eff) - BW'(border) - BW'(1));
    end
    if (state == S_INIT) begin
      best   <= '0;
      best_r <= '0;
      best_c <= '0;
      r      <= row_lo_q;
      c      <= col_lo_q;
    end
    if (state == S_SCAN) begin
      if (c == col_hi_q) begin
        c <= col_lo_q;
        r <= r + RB'(1);
      end else begin
        c <= c + CB'(1);
      end
    end
    if (state == S_EMIT && res_ready) begin
      pick_col[k[SIDX_W-1:0]] <= best_c;
      pick_row[k[SIDX_W-1:0]] <= best_r;
    end
  end

  // pass number stays below the pass count while busy
  a_pass_in_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (k < count_q))
    else $error("pass number beyond pass count");

  // tally never exceeds the passes already finished
  a_tally_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (tally <= k))
    else $error("found tally ahead of finished passes");

  // a found pick lies inside the interior
  a_pick_inside: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) && found |-> (best_r >= row_lo_q) && (best_r <= row_hi_q)
                                   && (best_c >= col_lo_q) && (best_c <= col_hi_q))
    else $error("pick outside the interior");

endmodule

// File: rtl/core/reference_star_picker_top.sv
// reference_star_picker_top: loads a frame and picks reference stars from it
// configuration registers, frame store, loader, pass sequencer, output register
// depends on rsp_pkg, rsp_ifs, rsp_frame_mem, rsp_loader, rsp_scan
//
// loading: one pixel per cycle while no pass runs, written into the frame store
// passes: each reads the N = (rows-4*radius)*(cols-4*radius) interior pixels
//   one per cycle from the single read port; none if the interior is empty
// the first result enters the output register from S_EMIT of the first pass;
//   a pass waits while the output register is full and not taken
// reset: registers to defaults, load position 0,0; the frame store is not cleared
module reference_star_picker_top #(
  parameter int MAX_ROWS   = 256,
  parameter int MAX_COLS   = 256,
  parameter int MAX_STARS  = 16,
  parameter int PIXEL_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [rsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsp_pkg::CFG_DATA_W-1:0] cfg_data,
  rsp_pixel_if.sink                      pixels,
  rsp_star_if.source                     stars
);

  localparam int RB = $clog2(MAX_ROWS);
  localparam int CB = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CW = $clog2(MAX_COLS + 1);

  // configuration registers
  logic [rsp_pkg::STAR_COUNT_W-1:0] star_count;
  logic [rsp_pkg::RADIUS_W-1:0]     exclusion_radius;
  logic [rsp_pkg::DIM_W-1:0]        image_rows;
  logic [rsp_pkg::DIM_W-1:0]        image_cols;

  logic                  accept;
  logic                  wr_en;
  logic [RB+CB-1:0]      wr_addr;
  logic                  start;
  logic [RW-1:0]         rows_eff;
  logic [CW-1:0]         cols_eff;
  logic                  scan_idle;
  logic                  rd_en;
  logic [RB+CB-1:0]      rd_addr;
  logic [PIXEL_BITS-1:0] rd_data;
  logic                  res_valid;
  logic                  res_ready;
  rsp_pkg::star_res_t    res;
  logic                  out_valid;
  rsp_pkg::star_res_t    out_data;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      star_count       <= rsp_pkg::STAR_COUNT_RST;
      exclusion_radius <= rsp_pkg::RADIUS_RST;
      image_rows       <= rsp_pkg::ROWS_RST;
      image_cols       <= rsp_pkg::COLS_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        rsp_pkg::REG_STAR_COUNT: star_count <= cfg_data[rsp_pkg::STAR_COUNT_W-1:0];
        rsp_pkg::REG_RADIUS:     exclusion_radius <= cfg_data[rsp_pkg::RADIUS_W-1:0];
        rsp_pkg::REG_ROWS:       image_rows <= cfg_data[rsp_pkg::DIM_W-1:0];
        rsp_pkg::REG_COLS:       image_cols <= cfg_data[rsp_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // pixels are taken only while no pass is running
  assign pixels.ready = scan_idle;
  assign accept       = pixels.valid && scan_idle;

  rsp_loader #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_loader (
    .clk       (clk),
    .rst       (rst),
    .image_rows(image_rows),
    .image_cols(image_cols),
    .accept    (accept),
    .frame_end (pixels.frame_end),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .start     (start),
    .rows_eff  (rows_eff),
    .cols_eff  (cols_eff)
  );

  rsp_frame_mem #(
    .ADDR_W(RB + CB),
    .DATA_W(PIXEL_BITS)
  ) u_frame_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(pixels.pixel_value),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  rsp_scan #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .MAX_STARS (MAX_STARS),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .rows_eff  (rows_eff),
    .cols_eff  (cols_eff),
    .star_count(star_count),
    .radius    (exclusion_radius),
    .idle      (scan_idle),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register
  assign res_ready = !out_valid || stars.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data <= res;
    end
  end

  assign stars.valid       = out_valid;
  assign stars.star_index  = out_data.star_index;
  assign stars.star_col    = out_data.star_col;
  assign stars.star_row    = out_data.star_row;
  assign stars.star_valid  = out_data.star_valid;
  assign stars.stars_total = out_data.stars_total;
  assign stars.all_found   = out_data.all_found;
  assign stars.last_star   = out_data.last_star;

endmodule
